### sv/apn_pkg.sv
// Shared types, codes and constant tables for the noise channel.
package apn_pkg;

    // Item kinds carried in the input tuser field.
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_ENV    = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // Channel register addresses.
    localparam logic [1:0] REG_ENV    = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int unsigned SAMPLE_W = 9;

    localparam longint unsigned CPU_CLOCK = 64'd1789772;
    localparam longint unsigned OUT_RATE  = 64'd44100;

    typedef logic [11:0] t_period_tab [16];
    typedef logic [7:0]  t_length_tab [32];

    localparam t_period_tab PERIOD_TABLE = '{
        12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
        12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
    };

    localparam t_length_tab LENGTH_TABLE = '{
        8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
        8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] reg_index;
        logic [7:0] write_data;
    } t_item;

endpackage

### sv/apn_voice.sv
// Channel state: register file, envelope, period counter and LFSR.
module apn_voice #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  apn_pkg::t_item                 i_item,
    input  logic                           i_enable,
    output logic [apn_pkg::SAMPLE_W-1:0]   o_sample
);
    import apn_pkg::*;

    // Longest period is a little over 1604 samples.
    localparam int THR_W = FRAC_BITS + 11;
    localparam int ACC_W = FRAC_BITS + 12;
    localparam logic [ACC_W-1:0] ONE_UNIT = ACC_W'(1) << FRAC_BITS;

    logic [THR_W-1:0] thr_tab [16];

    genvar g;
    generate
        for (g = 0; g < 16; g++) begin : g_thr
            localparam longint unsigned NUM =
                OUT_RATE * 64'd16 * (64'(PERIOD_TABLE[g]) + 64'd1);
            localparam longint unsigned THR =
                ((NUM << FRAC_BITS) + CPU_CLOCK / 2) / CPU_CLOCK;
            assign thr_tab[g] = THR_W'(THR);
        end
    endgenerate

    logic [14:0]      r_lfsr, n_lfsr;
    logic [3:0]       r_env_level, n_env_level;
    logic [7:0]       r_env_delay, n_env_delay;
    logic [3:0]       r_volume, n_volume;
    logic             r_fixed_env, n_fixed_env;
    logic             r_hold, n_hold;
    logic             r_short_mode, n_short_mode;
    logic [3:0]       r_period_sel, n_period_sel;
    logic [7:0]       r_length, n_length;
    logic [ACC_W-1:0] r_phase_acc, n_phase_acc;

    logic [ACC_W-1:0] acc_inc;
    logic [ACC_W-1:0] thr;
    logic             silent;
    logic             feedback;
    logic [3:0]       amp;

    always_comb begin
        n_lfsr       = r_lfsr;
        n_env_level  = r_env_level;
        n_env_delay  = r_env_delay;
        n_volume     = r_volume;
        n_fixed_env  = r_fixed_env;
        n_hold       = r_hold;
        n_short_mode = r_short_mode;
        n_period_sel = r_period_sel;
        n_length     = r_length;
        n_phase_acc  = r_phase_acc;

        silent   = !i_enable || (r_length == 8'd0);
        thr      = ACC_W'(thr_tab[r_period_sel]);
        acc_inc  = r_phase_acc + ONE_UNIT;
        feedback = r_lfsr[14] ^ (r_short_mode ? r_lfsr[8] : r_lfsr[13]);

        if (i_fire) begin
            case (i_item.action)
                ACT_WRITE: begin
                    unique case (i_item.reg_index)
                        REG_ENV: begin
                            n_volume    = i_item.write_data[3:0];
                            n_env_delay = {4'd0, i_item.write_data[3:0]};
                            n_fixed_env = i_item.write_data[4];
                            n_hold      = i_item.write_data[5];
                        end
                        REG_PERIOD: begin
                            n_period_sel = i_item.write_data[3:0];
                            n_short_mode = i_item.write_data[7];
                        end
                        REG_LENGTH: begin
                            n_length = LENGTH_TABLE[i_item.write_data[7:3]];
                        end
                        REG_UNUSED: begin
                        end
                        default: begin
                        end
                    endcase
                end
                ACT_ENV: begin
                    n_env_delay = r_env_delay - 8'd1;
                    if (!r_fixed_env && r_env_level != 4'd0 && n_env_delay == 8'd0) begin
                        n_env_level = r_env_level - 4'd1;
                        n_env_delay = {4'd0, r_volume};
                    end
                    if (r_hold && n_env_level == 4'd0) begin
                        n_env_level = 4'd15;
                    end
                end
                ACT_SAMPLE: begin
                    if (!silent) begin
                        if (acc_inc >= thr) begin
                            n_phase_acc = acc_inc - thr;
                            n_lfsr      = {r_lfsr[13:0], feedback};
                        end else begin
                            n_phase_acc = acc_inc;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // The sample reflects the LFSR after this tick's step.
        amp      = r_fixed_env ? r_volume : r_env_level;
        o_sample = (silent || !n_lfsr[0]) ? '0 : {amp, 5'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr       <= 15'd1;
            r_env_level  <= '0;
            r_env_delay  <= '0;
            r_volume     <= '0;
            r_fixed_env  <= 1'b0;
            r_hold       <= 1'b0;
            r_short_mode <= 1'b0;
            r_period_sel <= '0;
            r_length     <= '0;
            r_phase_acc  <= '0;
        end else begin
            r_lfsr       <= n_lfsr;
            r_env_level  <= n_env_level;
            r_env_delay  <= n_env_delay;
            r_volume     <= n_volume;
            r_fixed_env  <= n_fixed_env;
            r_hold       <= n_hold;
            r_short_mode <= n_short_mode;
            r_period_sel <= n_period_sel;
            r_length     <= n_length;
            r_phase_acc  <= n_phase_acc;
        end
    end

endmodule

### sv/apu_noise_channel_unit.sv
// Top level of the noise channel: input register, channel state and output register.
//
//  Channel   Direction  Handshake                 Payload
//  s_axis    in         i_s_axis_tvalid/tready    tuser: action; tdata: reg_index, write_data
//  m_axis    out        o_m_axis_tvalid/tready    tdata: sample
//  cfg       in         i_cfg_valid/o_cfg_ready   channel_enable
//
// One item per cycle unless a sample tick is held by an output stall: an item is held
// in the input register and applied to the channel state from there; the sample of a
// sample tick lands in the output register with that same state update.
// Reset is synchronous and active low; the configuration port is always ready.
// A sample tick waits in the input register only while a sample is still unclaimed
// at the output; writes and envelope ticks pass regardless of output stalls.
module apu_noise_channel_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [1:0] reg_index, [9:2] write_data, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [8:0] sample, rest zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import apn_pkg::*;

    logic                r_in_valid;
    t_item               r_item;
    logic                r_enable;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_sample;

    logic                is_sample;
    logic                fire;
    logic [SAMPLE_W-1:0] sample;

    assign is_sample       = (r_item.action == ACT_SAMPLE);
    assign fire            = r_in_valid && (!is_sample || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(16 - SAMPLE_W){1'b0}}, r_out_sample};

    apn_voice #(
        .FRAC_BITS (FRAC_BITS)
    ) u_voice (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_enable (r_enable),
        .o_sample (sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (fire && is_sample) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.action     <= i_s_axis_tuser;
            r_item.reg_index  <= i_s_axis_tdata[1:0];
            r_item.write_data <= i_s_axis_tdata[9:2];
        end
        if (fire && is_sample) begin
            r_out_sample <= sample;
        end
    end

endmodule
